FILE: src/atrc_pkg.sv
// shared types, codes and character tables for the response line classifier
package atrc_pkg;

  typedef enum logic [2:0] {
    CLS_NOTE   = 3'd0,
    CLS_IPD    = 3'd1,
    CLS_CLOSED = 3'd2,
    CLS_OK     = 3'd3,
    CLS_ERROR  = 3'd4,
    CLS_FAIL   = 3'd5,
    CLS_NONE   = 3'd6
  } line_class_t;

  // partial keyword match: O, E, ER, ERR, ERRO, F, FA, FAI
  typedef enum logic [3:0] {
    KW_IDLE = 4'd0,
    KW_O    = 4'd1,
    KW_E    = 4'd2,
    KW_ER   = 4'd3,
    KW_ERR  = 4'd4,
    KW_ERRO = 4'd5,
    KW_F    = 4'd6,
    KW_FA   = 4'd7,
    KW_FAI  = 4'd8
  } kw_prog_t;

  typedef enum logic [1:0] {
    FOUND_NONE  = 2'd0,
    FOUND_OK    = 2'd1,
    FOUND_ERROR = 2'd2,
    FOUND_FAIL  = 2'd3
  } kw_found_t;

  typedef struct packed {
    line_class_t line_class;
    logic [7:0]  note_index;
  } line_result_t;

  localparam logic [7:0] CH_NL    = 8'h0A;
  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_SHARP = 8'h23;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;

  localparam logic [3:0] SEMI_E = 4'd4;
  localparam logic [3:0] SEMI_B = 4'd11;

  function automatic logic [7:0] ipd_char(input logic [1:0] idx);
    logic [7:0] ch;
    unique case (idx)
      2'd0: ch = 8'h2B; // +
      2'd1: ch = 8'h49; // I
      2'd2: ch = 8'h50; // P
      2'd3: ch = 8'h44; // D
      default: ch = 8'h00;
    endcase
    return ch;
  endfunction

  function automatic logic [7:0] closed_char(input logic [2:0] idx);
    logic [7:0] ch;
    unique case (idx)
      3'd0: ch = 8'h43; // C
      3'd1: ch = 8'h4C; // L
      3'd2: ch = 8'h4F; // O
      3'd3: ch = 8'h53; // S
      3'd4: ch = 8'h45; // E
      3'd5: ch = 8'h44; // D
      default: ch = 8'h00;
    endcase
    return ch;
  endfunction

  // letter to semitone, msb is the valid flag
  function automatic logic [4:0] letter_semi(input logic [7:0] ch);
    logic [4:0] r;
    unique case (ch)
      8'h43: r = {1'b1, 4'd0};  // C
      8'h44: r = {1'b1, 4'd2};  // D
      8'h45: r = {1'b1, 4'd4};  // E
      8'h46: r = {1'b1, 4'd5};  // F
      8'h47: r = {1'b1, 4'd7};  // G
      8'h41: r = {1'b1, 4'd9};  // A
      8'h42: r = {1'b1, 4'd11}; // B
      default: r = 5'd0;
    endcase
    return r;
  endfunction

  function automatic kw_prog_t kw_start(input logic [7:0] ch);
    kw_prog_t k;
    priority case (ch)
      8'h4F: k = KW_O;  // O
      8'h45: k = KW_E;  // E
      8'h46: k = KW_F;  // F
      default: k = KW_IDLE;
    endcase
    return k;
  endfunction

endpackage

FILE: src/atrc_line.sv
// per-line scan state and the classification of a finished line
module atrc_line #(
  parameter int LINE_LIMIT = 64
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  step,
  input  logic [7:0]            rx_byte,
  output atrc_pkg::line_result_t result
);
  import atrc_pkg::*;

  localparam int PW = $clog2(LINE_LIMIT + 1);
  localparam logic [PW:0] LIMIT = (PW + 1)'(LINE_LIMIT);

  logic [PW-1:0] pos, pos_next;
  logic          ipd_ok, ipd_ok_next;
  logic          closed_ok, closed_ok_next;
  logic          colon_seen, colon_seen_next;
  logic [1:0]    off, off_next;
  logic [3:0]    semi, semi_next;
  logic          letter_valid, letter_valid_next;
  logic [7:0]    octave, octave_next;
  logic          digits_ended, digits_ended_next;
  logic          sharp, sharp_next;
  kw_prog_t      kw_prog, kw_prog_next;
  kw_found_t     kw_found, kw_found_next;
  logic          cut, cut_next;

  logic          is_nl, is_digit, clear;
  logic [PW:0]   pos_inc;
  logic [4:0]    letter;
  logic [7:0]    note;

  assign is_nl    = (rx_byte == CH_NL);
  assign is_digit = (rx_byte >= CH_ZERO) && (rx_byte <= CH_NINE);
  assign pos_inc  = {1'b0, pos} + (PW + 1)'(1);
  assign letter   = letter_semi(rx_byte);

  // octave*12 + semitone (+1 for a sharp on a letter that has one)
  always_comb begin
    note = {octave[4:0], 3'b000} + {octave[5:0], 2'b00} + {4'd0, semi};
    if (sharp && semi != SEMI_E && semi != SEMI_B) begin
      note = note + 8'd1;
    end
  end

  always_comb begin
    priority if (ipd_ok && pos >= PW'(4)) begin
      if (colon_seen && letter_valid) begin
        result.line_class = CLS_NOTE;
        result.note_index = note;
      end else begin
        result.line_class = CLS_IPD;
        result.note_index = 8'd0;
      end
    end else if (closed_ok && pos >= PW'(6)) begin
      result.line_class = CLS_CLOSED;
      result.note_index = 8'd0;
    end else begin
      unique case (kw_found)
        FOUND_OK:    result.line_class = CLS_OK;
        FOUND_ERROR: result.line_class = CLS_ERROR;
        FOUND_FAIL:  result.line_class = CLS_FAIL;
        default:     result.line_class = CLS_NONE;
      endcase
      result.note_index = 8'd0;
    end
  end

  always_comb begin
    pos_next          = pos;
    ipd_ok_next       = ipd_ok;
    closed_ok_next    = closed_ok;
    colon_seen_next   = colon_seen;
    off_next          = off;
    semi_next         = semi;
    letter_valid_next = letter_valid;
    octave_next       = octave;
    digits_ended_next = digits_ended;
    sharp_next        = sharp;
    kw_prog_next      = kw_prog;
    kw_found_next     = kw_found;
    cut_next          = cut;
    clear             = 1'b0;

    if (is_nl) begin
      clear = 1'b1;
    end else begin
      if (!cut) begin
        if (pos < PW'(4) && rx_byte != ipd_char(pos[1:0])) begin
          ipd_ok_next = 1'b0;
        end
        if (pos < PW'(6) && rx_byte != closed_char(pos[2:0])) begin
          closed_ok_next = 1'b0;
        end
        if (rx_byte == CH_NUL) begin
          cut_next = 1'b1;
        end else begin
          // keyword matcher, frozen once something is found
          if (kw_found == FOUND_NONE) begin
            kw_prog_next = kw_start(rx_byte);
            unique case (kw_prog)
              KW_O: begin
                if (rx_byte == 8'h4B) kw_found_next = FOUND_OK;
              end
              KW_E: begin
                if (rx_byte == 8'h52) kw_prog_next = KW_ER;
              end
              KW_ER: begin
                if (rx_byte == 8'h52) kw_prog_next = KW_ERR;
              end
              KW_ERR: begin
                if (rx_byte == 8'h4F) kw_prog_next = KW_ERRO;
              end
              KW_ERRO: begin
                if (rx_byte == 8'h52) kw_found_next = FOUND_ERROR;
                else if (rx_byte == 8'h4B) kw_found_next = FOUND_OK;
              end
              KW_F: begin
                if (rx_byte == 8'h41) kw_prog_next = KW_FA;
              end
              KW_FA: begin
                if (rx_byte == 8'h49) kw_prog_next = KW_FAI;
              end
              KW_FAI: begin
                if (rx_byte == 8'h4C) kw_found_next = FOUND_FAIL;
              end
              default: ;
            endcase
            if (kw_found_next != FOUND_NONE) begin
              kw_prog_next = kw_prog;
            end
          end
          // note text after the first colon
          if (!colon_seen) begin
            if (rx_byte == CH_COLON) colon_seen_next = 1'b1;
          end else begin
            if (off == 2'd0) begin
              letter_valid_next = letter[4];
              semi_next         = letter[3:0];
            end else begin
              if (!digits_ended) begin
                if (is_digit) begin
                  octave_next = {octave[6:0], 1'b0} + {octave[4:0], 3'b000}
                              + (rx_byte - CH_ZERO);
                end else begin
                  digits_ended_next = 1'b1;
                end
              end
              if (off == 2'd2 && rx_byte == CH_SHARP) sharp_next = 1'b1;
            end
            if (off != 2'd3) off_next = off + 2'd1;
          end
        end
      end
      pos_next = pos_inc[PW-1:0];
      if (pos_inc > LIMIT) clear = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || (step && clear)) begin
      pos          <= '0;
      ipd_ok       <= 1'b1;
      closed_ok    <= 1'b1;
      colon_seen   <= 1'b0;
      off          <= 2'd0;
      semi         <= 4'd0;
      letter_valid <= 1'b0;
      octave       <= 8'd0;
      digits_ended <= 1'b0;
      sharp        <= 1'b0;
      kw_prog      <= KW_IDLE;
      kw_found     <= FOUND_NONE;
      cut          <= 1'b0;
    end else if (step) begin
      pos          <= pos_next;
      ipd_ok       <= ipd_ok_next;
      closed_ok    <= closed_ok_next;
      colon_seen   <= colon_seen_next;
      off          <= off_next;
      semi         <= semi_next;
      letter_valid <= letter_valid_next;
      octave       <= octave_next;
      digits_ended <= digits_ended_next;
      sharp        <= sharp_next;
      kw_prog      <= kw_prog_next;
      kw_found     <= kw_found_next;
      cut          <= cut_next;
    end
  end

`ifndef SYNTHESIS
  a_pos_limit: assert property (@(posedge clk) disable iff (rst)
    {1'b0, pos} <= LIMIT)
    else $error("line position beyond limit");

  a_found_freezes: assert property (@(posedge clk) disable iff (rst)
    (kw_found != FOUND_NONE && !(step && clear)) |=> $stable(kw_found))
    else $error("keyword result changed within a line");
`endif

endmodule

FILE: src/at_response_line_classifier.sv
// top level of the modem response line classifier: input and result registers
//
//  channel  | dir | tdata fields (lsb up)                      | tuser/tlast
//  s_axis   | in  | rx_byte[7:0]                               | none
//  m_axis   | out | line_class[2:0], note_index[10:3], 0 pad   | none
//
// one byte per cycle sustained: a byte goes into the input register, then the
// line scan updates in one pass and a newline loads the result register
// a newline waits in the input register only while the result register is
// full and not being taken; other bytes never wait
// rst (synchronous) empties both registers and restarts the line state
module at_response_line_classifier #(
  parameter int LINE_LIMIT = 64
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // rx_byte[7:0]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata    // line_class[2:0], note_index[10:3], zero[15:11]
);
  import atrc_pkg::*;

  logic         in_full;
  logic [7:0]   in_byte;
  logic         is_nl;
  logic         out_free;
  logic         proc;
  line_result_t line_res;
  line_result_t out_res;
  logic         out_valid;

  assign is_nl    = (in_byte == CH_NL);
  // result register can take a new item this cycle
  assign out_free = !out_valid || m_axis_tready;
  // the held byte leaves the input register
  assign proc     = in_full && (!is_nl || out_free);
  assign s_axis_tready = !in_full || proc;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (s_axis_tvalid && s_axis_tready) begin
      in_full <= 1'b1;
    end else if (proc) begin
      in_full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_byte <= s_axis_tdata;
    end
  end

  atrc_line #(
    .LINE_LIMIT(LINE_LIMIT)
  ) u_line (
    .clk     (clk),
    .rst     (rst),
    .step    (proc),
    .rx_byte (in_byte),
    .result  (line_res)
  );

  // result register, loaded on a newline
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (proc && is_nl) begin
      out_valid <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (proc && is_nl) begin
      out_res <= line_res;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {5'd0, out_res.note_index, out_res.line_class};

`ifndef SYNTHESIS
  a_result_from_newline: assert property (@(posedge clk) disable iff (rst)
    !out_valid |=> (!out_valid || $past(proc && is_nl)))
    else $error("result appeared without a newline");

  a_note_only_for_note: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_res.line_class != CLS_NOTE) |-> out_res.note_index == 8'd0)
    else $error("note index set on a non-note line");

  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    !s_axis_tready |-> (in_full && is_nl && out_valid && !m_axis_tready))
    else $error("input stalled without a blocked newline");
`endif

endmodule

FILE: tb/tb.sv
// testbench for the modem response line classifier: byte stream in, line classes out
`timescale 1ns / 100ps

module tb;
  import atrc_pkg::*;

  // keeps its own copy of the line scan and the queue of line results still owed
  class line_scoreboard;
    int unsigned line_pos;
    bit          ipd_possible;
    bit          closed_possible;
    bit          colon_seen;
    int unsigned colon_offset;
    logic [3:0]  semitone;
    bit          letter_ok;
    logic [7:0]  octave;
    bit          digits_done;
    bit          sharp_seen;
    bit          line_cut;
    kw_prog_t    kw_prog;
    kw_found_t   kw_found;
    int          line_limit;
    string       ipd_txt = "+IPD";
    string       closed_txt = "CLOSED";

    line_result_t owed_q[$];
    int errors;
    int lines_checked;
    int notes_checked;

    function new(int limit);
      line_limit = limit;
      clear_line();
    endfunction

    function void clear_line();
      line_pos        = 0;
      ipd_possible    = 1'b1;
      closed_possible = 1'b1;
      colon_seen      = 1'b0;
      colon_offset    = 0;
      semitone        = 4'd0;
      letter_ok       = 1'b0;
      octave          = 8'd0;
      digits_done     = 1'b0;
      sharp_seen      = 1'b0;
      line_cut        = 1'b0;
      kw_prog         = KW_IDLE;
      kw_found        = FOUND_NONE;
    endfunction

    function void scan_keyword(logic [7:0] c);
      case (kw_prog)
        KW_O:    if (c == "K") begin kw_found = FOUND_OK; return; end
        KW_E:    if (c == "R") begin kw_prog = KW_ER; return; end
        KW_ER:   if (c == "R") begin kw_prog = KW_ERR; return; end
        KW_ERR:  if (c == "O") begin kw_prog = KW_ERRO; return; end
        KW_ERRO: begin
          if (c == "R") begin kw_found = FOUND_ERROR; return; end
          if (c == "K") begin kw_found = FOUND_OK; return; end
        end
        KW_F:    if (c == "A") begin kw_prog = KW_FA; return; end
        KW_FA:   if (c == "I") begin kw_prog = KW_FAI; return; end
        KW_FAI:  if (c == "L") begin kw_found = FOUND_FAIL; return; end
        default: ;
      endcase
      // a failed partial match may itself start a new keyword
      if (c == "O") kw_prog = KW_O;
      else if (c == "E") kw_prog = KW_E;
      else if (c == "F") kw_prog = KW_F;
      else kw_prog = KW_IDLE;
    endfunction

    function void scan_note(logic [7:0] c);
      if (!colon_seen) begin
        if (c == CH_COLON) colon_seen = 1'b1;
        return;
      end
      if (colon_offset == 0) begin
        letter_ok = 1'b1;
        case (c)
          "C": semitone = 4'd0;
          "D": semitone = 4'd2;
          "E": semitone = 4'd4;
          "F": semitone = 4'd5;
          "G": semitone = 4'd7;
          "A": semitone = 4'd9;
          "B": semitone = 4'd11;
          default: begin
            letter_ok = 1'b0;
            semitone  = 4'd0;
          end
        endcase
      end else begin
        if (!digits_done) begin
          if (c >= CH_ZERO && c <= CH_NINE) octave = octave * 8'd10 + (c - CH_ZERO);
          else digits_done = 1'b1;
        end
        if (colon_offset == 2 && c == CH_SHARP) sharp_seen = 1'b1;
      end
      if (colon_offset < 3) colon_offset++;
    endfunction

    // accepted byte: advance the line scan, a newline owes one result
    function void note_byte(logic [7:0] c);
      line_result_t r;
      int unsigned  v;
      if (c == CH_NL) begin
        r.note_index = 8'd0;
        if (ipd_possible && line_pos >= 4) begin
          if (colon_seen && letter_ok) begin
            v = octave * 12 + semitone;
            if (sharp_seen && semitone != SEMI_E && semitone != SEMI_B) v++;
            r.note_index = v[7:0];
            r.line_class = CLS_NOTE;
          end else begin
            r.line_class = CLS_IPD;
          end
        end else if (closed_possible && line_pos >= 6) begin
          r.line_class = CLS_CLOSED;
        end else begin
          case (kw_found)
            FOUND_OK:    r.line_class = CLS_OK;
            FOUND_ERROR: r.line_class = CLS_ERROR;
            FOUND_FAIL:  r.line_class = CLS_FAIL;
            default:     r.line_class = CLS_NONE;
          endcase
        end
        owed_q.push_back(r);
        clear_line();
        return;
      end
      if (!line_cut) begin
        if (line_pos < 4 && c != ipd_txt[line_pos]) ipd_possible = 1'b0;
        if (line_pos < 6 && c != closed_txt[line_pos]) closed_possible = 1'b0;
        if (c == CH_NUL) begin
          line_cut = 1'b1;
        end else begin
          if (kw_found == FOUND_NONE) scan_keyword(c);
          scan_note(c);
        end
      end
      line_pos++;
      // over-long line: everything so far is dropped
      if (line_pos > line_limit) clear_line();
    endfunction

    function void check_result(logic [15:0] data);
      line_result_t want;
      if (owed_q.size() == 0) begin
        $display("%0t: unexpected result, actual tdata %h", $time, data);
        errors++;
        return;
      end
      want = owed_q.pop_front();
      lines_checked++;
      if (want.line_class == CLS_NOTE) notes_checked++;
      if (data[2:0] != want.line_class) begin
        $display("%0t: line_class mismatch, expected %0d, actual %0d",
                 $time, want.line_class, data[2:0]);
        errors++;
      end
      if (data[10:3] != want.note_index) begin
        $display("%0t: note_index mismatch, expected %0d, actual %0d",
                 $time, want.note_index, data[10:3]);
        errors++;
      end
      if (data[15:11] != 5'd0) begin
        $display("%0t: tdata padding mismatch, expected 0, actual %h", $time, data[15:11]);
        errors++;
      end
    endfunction

    function int pending();
      return owed_q.size();
    endfunction
  endclass

  localparam int LINE_LIMIT   = 64;
  localparam int BYTES_TARGET = 1350;
  localparam int WATCHDOG     = 5000;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata = 8'd0;   // rx_byte[7:0]
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [15:0] m_axis_tdata;          // line_class[2:0], note_index[10:3], zero[15:11]

  int send_idle  = 0;   // percent of cycles the sender holds back
  int recv_stall = 0;   // percent of cycles the receiver stalls
  int bytes_sent = 0;
  int stall_cycles = 0;
  int phase_quota = 0;  // bytes per random phase: a quarter of (target - sent - 40)
  bit moved;

  line_scoreboard sb;

  at_response_line_classifier #(.LINE_LIMIT(LINE_LIMIT)) u_top (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // receiver back-pressure, redrawn every cycle
  always @(posedge clk) begin
    m_axis_tready <= ($urandom_range(0, 99) >= recv_stall);
  end

  // both handshakes are sampled here with pre-edge values; input side first
  always @(posedge clk) begin
    if (!rst) begin
      moved = 1'b0;
      if (s_axis_tvalid && s_axis_tready) begin
        sb.note_byte(s_axis_tdata);
        moved = 1'b1;
      end
      if (m_axis_tvalid && m_axis_tready) begin
        sb.check_result(m_axis_tdata);
        moved = 1'b1;
      end
      if (moved) stall_cycles = 0;
      else stall_cycles++;
      if (stall_cycles >= WATCHDOG) begin
        $display("%0t: no handshake for %0d cycles, %0d results outstanding",
                 $time, WATCHDOG, sb.pending());
        $display("status: fail");
        $finish;
      end
    end
  end

  // one item; returns at the edge that takes it, tvalid left high
  task automatic send_byte(input logic [7:0] b);
    while ($urandom_range(0, 99) < send_idle) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    bytes_sent++;
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_byte(s[i]);
  endtask

  task automatic send_run(input logic [7:0] ch, input int n);
    for (int i = 0; i < n; i++) send_byte(ch);
  endtask

  function automatic logic [7:0] pick(input string s);
    return s[$urandom_range(0, s.len() - 1)];
  endfunction

  // one random line ending in a newline; mostly well-formed messages
  task automatic random_line();
    int    kind;
    int    n;
    string pre;
    kind = $urandom_range(0, 99);
    if (kind < 35) begin
      // note message, sometimes with a broken prefix or no colon
      pre = "+IPD";
      if ($urandom_range(0, 99) < 12) pre[$urandom_range(0, 3)] = pick("+IPDCx");
      send_text(pre);
      n = $urandom_range(0, 6);
      for (int i = 0; i < n; i++) send_byte(pick(",0123456789"));
      if ($urandom_range(0, 99) < 90) send_byte(CH_COLON);
      if ($urandom_range(0, 99) < 92) send_byte(pick("ABCDEFGABCDEFGHx#:"));
      n = $urandom_range(0, 4);
      for (int i = 0; i < n; i++) send_byte(pick("0123456789"));
      if ($urandom_range(0, 99) < 35) send_byte(CH_SHARP);
      n = $urandom_range(0, 3);
      for (int i = 0; i < n; i++) send_byte(pick("#:,9 xOK"));
    end else if (kind < 45) begin
      pre = "CLOSED";
      if ($urandom_range(0, 99) < 25) pre[$urandom_range(0, 5)] = pick("CLOSEDx+");
      n = $urandom_range(3, 6);
      send_text(pre.substr(0, n - 1));
      n = $urandom_range(0, 5);
      for (int i = 0; i < n; i++) send_byte(pick("OKERRFAIL "));
    end else if (kind < 75) begin
      n = $urandom_range(0, 20);
      for (int i = 0; i < n; i++) send_byte(pick("OKERRORFAILXC+:# 0"));
    end else if (kind < 85) begin
      // raw noise, may hold further newlines and zero bytes
      n = $urandom_range(0, 12);
      for (int i = 0; i < n; i++) send_byte(8'($urandom_range(0, 255)));
    end else if (kind < 92) begin
      // near or past the line limit
      n = $urandom_range(LINE_LIMIT - 4, LINE_LIMIT + 16);
      for (int i = 0; i < n; i++) send_byte(pick("OKERRORFAILx+IPD:C4"));
    end else begin
      n = $urandom_range(0, 4);
      for (int i = 0; i < n; i++) send_byte(pick("+IPDOKERF"));
      send_byte(CH_NUL);
      n = $urandom_range(0, 6);
      for (int i = 0; i < n; i++) send_byte(pick("OK:C4ERROR"));
    end
    send_byte(CH_NL);
  endtask

  task automatic random_phase(input int idle_pct, input int stall_pct, input int quota);
    int stop_at;
    send_idle  = idle_pct;
    recv_stall = stall_pct;
    stop_at    = bytes_sent + quota;
    while (bytes_sent < stop_at) random_line();
  endtask

  initial begin
    sb = new(LINE_LIMIT);
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed lines: notes, sharps, octave wrap, broken notes, every class
    send_text("+IPD,1,4:C4\n");
    send_text("+IPD:A3#\n");
    send_text("+IPD:E5#\n");          // no sharp on E
    send_text("+IPD:B1#\n");          // nor on B
    send_text("+IPD:C#4\n");          // sharp too early, no octave digits
    send_text("+IPD:G999\n");         // octave wraps
    send_text("+IPD,5\n");            // no colon
    send_text("+IPD:H2\n");           // unknown letter
    send_text("+IPD:\n");             // no letter
    send_text("+IPD\n");
    send_text("+IP OK\n");
    send_text("CLOSED OK\n");
    send_text("CLOSE\n");
    send_text("OK\nERROR\nFAIL\n");
    send_text("ERROK\n");             // overlapping keywords
    send_text("xFAILxOK\n");
    send_text("\n");
    send_text("O");
    send_byte(CH_NUL);                // zero byte hides the rest of the line
    send_text("K\n");
    send_text("+IPD:");
    send_byte(8'hFF);
    send_byte(8'h80);
    send_byte(CH_NL);
    send_text("OK");                  // exactly at the limit
    send_run("x", LINE_LIMIT - 2);
    send_byte(CH_NL);
    send_text("OK");                  // one past the limit drops the keyword
    send_run("x", LINE_LIMIT - 1);
    send_text("FAIL\n");

    phase_quota = (BYTES_TARGET - bytes_sent - 40) / 4;
    random_phase(0, 0, phase_quota);
    random_phase(86, 0, phase_quota);
    random_phase(0, 86, phase_quota);
    random_phase(30, 30, phase_quota);
    send_idle = 0;
    random_phase(0, 0, 40);
    s_axis_tvalid <= 1'b0;

    while (sb.pending() != 0) @(posedge clk);
    repeat (8) @(posedge clk);

    $display("sent %0d bytes, checked %0d line results (%0d notes), %0d errors",
             bytes_sent, sb.lines_checked, sb.notes_checked, sb.errors);
    $display("flow control: free running, sender gaps, receiver stalls and both mixed");
    if (sb.errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end
endmodule
